FILE: hw/rtl/tqsu_pkg.sv
package tqsu_pkg;

  // sizing
  localparam int MAX_TASKS = 16;
  localparam int NUM_SEMS  = 8;
  localparam int ID_W      = 5;
  localparam int IDX_W     = $clog2(MAX_TASKS);
  localparam int SEM_W     = 3;
  localparam int CNT_W     = 8;
  localparam int ENTRY_W   = 32;

  // actions
  localparam logic [1:0] ACT_CREATE = 2'd0;
  localparam logic [1:0] ACT_START  = 2'd1;
  localparam logic [1:0] ACT_P      = 2'd2;
  localparam logic [1:0] ACT_V      = 2'd3;

  // result status codes
  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_NOSLOT = 2'd1;
  localparam logic [1:0] STATUS_HALT   = 2'd2;
  localparam logic [1:0] STATUS_NOWAIT = 2'd3;

  // datapath commands
  localparam logic [3:0] CMD_NOP      = 4'd0;
  localparam logic [3:0] CMD_LATCH    = 4'd1;
  localparam logic [3:0] CMD_CLAIM    = 4'd2;
  localparam logic [3:0] CMD_COUNT    = 4'd3;
  localparam logic [3:0] CMD_NEW_RUN  = 4'd4;
  localparam logic [3:0] CMD_HEAD     = 4'd5;
  localparam logic [3:0] CMD_WALK     = 4'd6;
  localparam logic [3:0] CMD_TAIL     = 4'd7;
  localparam logic [3:0] CMD_CLEAR    = 4'd8;
  localparam logic [3:0] CMD_POP_ADDR = 4'd9;
  localparam logic [3:0] CMD_POP_RUN  = 4'd10;
  localparam logic [3:0] CMD_POP_WAKE = 4'd11;
  localparam logic [3:0] CMD_FINISH   = 4'd12;

  typedef struct packed {
    logic [1:0]         action;
    logic [SEM_W-1:0]   sem_index;
    logic [ENTRY_W-1:0] task_entry;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0] task_id;
    logic            switched;
    logic [1:0]      status;
  } out_item_t;

  typedef struct packed {
    logic [3:0] op;
    logic       sel_wait;
    logic [1:0] res_status;
  } cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       sem_ok;
    logic       free_none;
    logic       cnt_neg;
    logic       cnt_nonpos;
    logic       run_zero;
    logic       head_zero;
    logic       walk_more;
    logic       ptr_zero;
    logic       out_busy;
  } dp_status_t;

endpackage

FILE: hw/rtl/task_queue_semaphore_unit_top.sv
// Task and counting-semaphore manager. Each request (create, start, P, V)
// returns exactly one result: the created or running task id, a switched
// flag and a status code. Requests are handled one at a time. The longest
// are a blocking P and a V that wakes a task into a long ready queue, because
// appending to a ready or wait queue walks the linked list to its tail one
// link per cycle through the single read port of the link table. A finished
// result sits in an output register while the next request is accepted; a
// request whose result finds that register still held waits until it drains.
module task_queue_semaphore_unit_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tqsu_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tqsu_pkg::out_item_t out_data
);

  tqsu_pkg::cmd_t       cmd;
  tqsu_pkg::dp_status_t st;

  // sequencer
  tqsu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // queues, semaphores and result register
  tqsu_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

FILE: hw/rtl/tqsu_ctrl.sv
module tqsu_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tqsu_pkg::dp_status_t st,
  output tqsu_pkg::cmd_t      cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_APP   = 4'd3;
  localparam logic [3:0] S_WALK  = 4'd4;
  localparam logic [3:0] S_CLR   = 4'd5;
  localparam logic [3:0] S_POPA  = 4'd6;
  localparam logic [3:0] S_POPD  = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  logic [3:0] state, state_next;
  logic       qwait, qwait_next;
  logic       app_pop, app_pop_next;
  logic       pop_wake, pop_wake_next;
  logic [1:0] res_st, res_st_next;

  assign in_ready = (state == S_IDLE);

  // state and sequencing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      qwait    <= 1'b0;
      app_pop  <= 1'b0;
      pop_wake <= 1'b0;
      res_st   <= tqsu_pkg::STATUS_OK;
    end else begin
      state    <= state_next;
      qwait    <= qwait_next;
      app_pop  <= app_pop_next;
      pop_wake <= pop_wake_next;
      res_st   <= res_st_next;
    end
  end

  // next state and command decode
  always_comb begin
    state_next     = state;
    qwait_next     = qwait;
    app_pop_next   = app_pop;
    pop_wake_next  = pop_wake;
    res_st_next    = res_st;
    cmd.op         = tqsu_pkg::CMD_NOP;
    cmd.sel_wait   = qwait;
    cmd.res_status = res_st;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op      = tqsu_pkg::CMD_LATCH;
          res_st_next = tqsu_pkg::STATUS_OK;
          state_next  = S_DISP;
        end
      end
      S_DISP: begin
        case (st.action)
          tqsu_pkg::ACT_CREATE: begin
            if (st.free_none) begin
              res_st_next = tqsu_pkg::STATUS_NOSLOT;
              state_next  = S_FIN;
            end else begin
              cmd.op       = tqsu_pkg::CMD_CLAIM;
              qwait_next   = 1'b0;
              app_pop_next = 1'b0;
              state_next   = S_APP;
            end
          end
          tqsu_pkg::ACT_START: begin
            qwait_next    = 1'b0;
            pop_wake_next = 1'b0;
            state_next    = S_POPA;
          end
          default: begin
            if (!st.sem_ok) begin
              state_next = S_FIN;
            end else begin
              cmd.op     = tqsu_pkg::CMD_COUNT;
              state_next = S_CHECK;
            end
          end
        endcase
      end
      S_CHECK: begin
        if (st.action == tqsu_pkg::ACT_P) begin
          if (!st.cnt_neg) begin
            state_next = S_FIN;
          end else if (st.run_zero) begin
            res_st_next = tqsu_pkg::STATUS_HALT;
            state_next  = S_FIN;
          end else begin
            cmd.op       = tqsu_pkg::CMD_NEW_RUN;
            qwait_next   = 1'b1;
            app_pop_next = 1'b1;
            state_next   = S_APP;
          end
        end else begin
          if (!st.cnt_nonpos) begin
            state_next = S_FIN;
          end else begin
            qwait_next    = 1'b1;
            pop_wake_next = 1'b1;
            state_next    = S_POPA;
          end
        end
      end
      S_APP: begin
        cmd.op     = tqsu_pkg::CMD_HEAD;
        state_next = st.head_zero ? S_CLR : S_WALK;
      end
      S_WALK: begin
        if (st.walk_more) begin
          cmd.op = tqsu_pkg::CMD_WALK;
        end else begin
          cmd.op     = tqsu_pkg::CMD_TAIL;
          state_next = S_CLR;
        end
      end
      S_CLR: begin
        cmd.op = tqsu_pkg::CMD_CLEAR;
        if (app_pop) begin
          qwait_next    = 1'b0;
          pop_wake_next = 1'b0;
          state_next    = S_POPA;
        end else begin
          state_next = S_FIN;
        end
      end
      S_POPA: begin
        cmd.op     = tqsu_pkg::CMD_POP_ADDR;
        state_next = S_POPD;
      end
      S_POPD: begin
        if (pop_wake) begin
          cmd.op = tqsu_pkg::CMD_POP_WAKE;
          if (st.ptr_zero) begin
            res_st_next = tqsu_pkg::STATUS_NOWAIT;
            state_next  = S_FIN;
          end else begin
            qwait_next   = 1'b0;
            app_pop_next = 1'b0;
            state_next   = S_APP;
          end
        end else begin
          cmd.op = tqsu_pkg::CMD_POP_RUN;
          if (st.ptr_zero) begin
            res_st_next = tqsu_pkg::STATUS_HALT;
          end
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!st.out_busy) begin
          cmd.op     = tqsu_pkg::CMD_FINISH;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/tqsu_datapath.sv
module tqsu_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  tqsu_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tqsu_pkg::out_item_t  out_data,
  input  tqsu_pkg::cmd_t       cmd,
  output tqsu_pkg::dp_status_t st
);

  logic [tqsu_pkg::MAX_TASKS-1:0] used;
  logic [tqsu_pkg::ID_W-1:0]      link_next [tqsu_pkg::MAX_TASKS];
  logic [tqsu_pkg::ENTRY_W-1:0]   slot_entry [tqsu_pkg::MAX_TASKS];
  logic [tqsu_pkg::ID_W-1:0]      ready_head;
  logic [tqsu_pkg::ID_W-1:0]      sem_wait_head [tqsu_pkg::NUM_SEMS];
  logic signed [tqsu_pkg::CNT_W-1:0] sem_count [tqsu_pkg::NUM_SEMS];
  logic [tqsu_pkg::ID_W-1:0]      running_task;

  logic [1:0]                     lat_action;
  logic [tqsu_pkg::SEM_W-1:0]     lat_sem;
  logic [tqsu_pkg::ENTRY_W-1:0]   lat_entry;
  logic [tqsu_pkg::ID_W-1:0]      old_run;
  logic [tqsu_pkg::ID_W-1:0]      new_id;
  logic [tqsu_pkg::ID_W-1:0]      ptr;
  logic [tqsu_pkg::ID_W-1:0]      steps;

  logic [tqsu_pkg::ID_W-1:0]      free_id;
  logic                           free_none;
  logic [tqsu_pkg::ID_W-1:0]      head_sel;
  logic [tqsu_pkg::ID_W-1:0]      link_rd;
  logic signed [tqsu_pkg::CNT_W-1:0] cnt_cur;
  logic signed [tqsu_pkg::CNT_W-1:0] cnt_new;
  logic                           sem_ok;
  logic [tqsu_pkg::ID_W-1:0]      res_tid;
  logic                           res_sw;

  // lowest free slot
  always_comb begin
    free_id = '0;
    for (int i = tqsu_pkg::MAX_TASKS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_id = tqsu_pkg::ID_W'(i + 1);
      end
    end
  end
  assign free_none = &used;

  // queue head and link read port
  assign head_sel = cmd.sel_wait ? sem_wait_head[lat_sem] : ready_head;
  assign link_rd  = link_next[tqsu_pkg::IDX_W'(ptr - 1'b1)];

  // saturating count update
  assign sem_ok  = (32'(lat_sem) < 32'(tqsu_pkg::NUM_SEMS));
  assign cnt_cur = sem_count[lat_sem];
  always_comb begin
    cnt_new = cnt_cur;
    if (lat_action == tqsu_pkg::ACT_P) begin
      if (cnt_cur != {1'b1, {(tqsu_pkg::CNT_W-1){1'b0}}}) begin
        cnt_new = cnt_cur - tqsu_pkg::CNT_W'(1);
      end
    end else begin
      if (cnt_cur != {1'b0, {(tqsu_pkg::CNT_W-1){1'b1}}}) begin
        cnt_new = cnt_cur + tqsu_pkg::CNT_W'(1);
      end
    end
  end

  // result fields
  always_comb begin
    if (lat_action == tqsu_pkg::ACT_CREATE) begin
      res_tid = (cmd.res_status == tqsu_pkg::STATUS_NOSLOT) ? '0 : new_id;
    end else begin
      res_tid = running_task;
    end
    res_sw = ((lat_action == tqsu_pkg::ACT_START) || (lat_action == tqsu_pkg::ACT_P))
             && (running_task != old_run);
  end

  // status to controller
  always_comb begin
    st.action     = lat_action;
    st.sem_ok     = sem_ok;
    st.free_none  = free_none;
    st.cnt_neg    = cnt_cur < 0;
    st.cnt_nonpos = cnt_cur <= 0;
    st.run_zero   = (running_task == '0);
    st.head_zero  = (head_sel == '0);
    st.walk_more  = (link_rd != '0) && (32'(steps) < 32'(tqsu_pkg::MAX_TASKS));
    st.ptr_zero   = (ptr == '0);
    st.out_busy   = out_valid && !out_ready;
  end

  // scheduler state
  always_ff @(posedge clk) begin
    if (rst) begin
      used         <= '0;
      ready_head   <= '0;
      running_task <= '0;
      out_valid    <= 1'b0;
      for (int i = 0; i < tqsu_pkg::MAX_TASKS; i++) begin
        link_next[i] <= '0;
      end
      for (int s = 0; s < tqsu_pkg::NUM_SEMS; s++) begin
        sem_wait_head[s] <= '0;
        sem_count[s]     <= tqsu_pkg::CNT_W'(1);
      end
    end else begin
      // a new result takes the place of one leaving in the same cycle
      if (cmd.op == tqsu_pkg::CMD_FINISH) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        tqsu_pkg::CMD_CLAIM: begin
          used[tqsu_pkg::IDX_W'(free_id - 1'b1)] <= 1'b1;
        end
        tqsu_pkg::CMD_COUNT: begin
          sem_count[lat_sem] <= cnt_new;
        end
        tqsu_pkg::CMD_HEAD: begin
          if (head_sel == '0) begin
            if (cmd.sel_wait) begin
              sem_wait_head[lat_sem] <= new_id;
            end else begin
              ready_head <= new_id;
            end
          end
        end
        tqsu_pkg::CMD_TAIL: begin
          link_next[tqsu_pkg::IDX_W'(ptr - 1'b1)] <= new_id;
        end
        tqsu_pkg::CMD_CLEAR: begin
          link_next[tqsu_pkg::IDX_W'(new_id - 1'b1)] <= '0;
        end
        tqsu_pkg::CMD_POP_RUN, tqsu_pkg::CMD_POP_WAKE: begin
          if (ptr != '0) begin
            if (cmd.sel_wait) begin
              sem_wait_head[lat_sem] <= link_rd;
            end else begin
              ready_head <= link_rd;
            end
          end
          if (cmd.op == tqsu_pkg::CMD_POP_RUN) begin
            running_task <= ptr;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // item and walk registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      tqsu_pkg::CMD_LATCH: begin
        lat_action <= in_data.action;
        lat_sem    <= in_data.sem_index;
        lat_entry  <= in_data.task_entry;
        old_run    <= running_task;
      end
      tqsu_pkg::CMD_CLAIM: begin
        new_id <= free_id;
      end
      tqsu_pkg::CMD_NEW_RUN: begin
        new_id <= running_task;
      end
      tqsu_pkg::CMD_HEAD: begin
        ptr   <= head_sel;
        steps <= '0;
      end
      tqsu_pkg::CMD_WALK: begin
        ptr   <= link_rd;
        steps <= steps + 1'b1;
      end
      tqsu_pkg::CMD_POP_ADDR: begin
        ptr <= head_sel;
      end
      tqsu_pkg::CMD_POP_WAKE: begin
        new_id <= ptr;
      end
      tqsu_pkg::CMD_FINISH: begin
        out_data.task_id  <= res_tid;
        out_data.switched <= res_sw;
        out_data.status   <= cmd.res_status;
      end
      default: begin
      end
    endcase
  end

  // entry word store
  always_ff @(posedge clk) begin
    if (cmd.op == tqsu_pkg::CMD_CLAIM) begin
      slot_entry[tqsu_pkg::IDX_W'(free_id - 1'b1)] <= lat_entry;
    end
  end

endmodule

FILE: hw/rtl/tqsu_checker.sv
module tqsu_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input tqsu_pkg::out_item_t out_data,
  input logic                out_valid,
  input logic                out_ready
);

  // a stalled result stays put
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  // one request at a time
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  // failed create reports no task
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == tqsu_pkg::STATUS_NOSLOT
    |-> out_data.task_id == '0 && !out_data.switched)
    else $error("no-slot result carries a task");

  // task ids stay in range
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> 32'(out_data.task_id) <= 32'(tqsu_pkg::MAX_TASKS))
    else $error("task id out of range");

  // a signal with no waiting task never switches the running task
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == tqsu_pkg::STATUS_NOWAIT |-> !out_data.switched)
    else $error("switch reported on signal");

endmodule

bind task_queue_semaphore_unit_top tqsu_checker u_tqsu_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_data  (out_data),
  .out_valid (out_valid),
  .out_ready (out_ready)
);
